// ===== hdl/mcid_pkg.sv =====
// Shared types and constants for the multi-channel input debouncer.
// Used by mcid_lane, mcid_merge and multi_channel_input_debounce_top.
// Depends on nothing.
`default_nettype none

package mcid_pkg;

    // Fixed field widths of the scan and result transactions
    localparam int FIELD_W   = 12;
    localparam int THRESH_W  = 8;
    localparam int COUNT_W   = THRESH_W + 1;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [FIELD_W-1:0]  ENABLE_MASK_RST      = 12'd0;
    localparam logic [FIELD_W-1:0]  ACTIVE_HIGH_MASK_RST = 12'hFFF;
    localparam logic [THRESH_W-1:0] STABLE_THRESHOLD_RST = 8'd5;

    // Per-channel debounce phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } phase_t;

    // What one lane reports for the scan being accepted
    typedef struct packed {
        logic status;   // status after this scan
        logic rise;     // status went inactive -> active in this scan
    } lane_res_t;

endpackage

`default_nettype wire

// ===== hdl/mcid_lane.sv =====
// One debounce lane: phase, match counter and status of a single channel.
// Depends on mcid_pkg.
`default_nettype none

module mcid_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          level,
    input  wire logic                          enable,
    input  wire logic                          active_high,
    input  wire logic [mcid_pkg::THRESH_W-1:0] threshold,
    output mcid_pkg::lane_res_t                res
);

    mcid_pkg::phase_t                 phase_reg, phase_next;
    logic [mcid_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             status_reg, status_next;
    logic [mcid_pkg::COUNT_W-1:0]     count_inc;
    logic                             want;
    logic                             rise;

    assign count_inc = count_reg + mcid_pkg::COUNT_W'(1);
    assign want      = (phase_reg == mcid_pkg::PH_HIGH);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rise        = 1'b0;
        if (enable)
        begin
            case (phase_reg)
                mcid_pkg::PH_HIGH, mcid_pkg::PH_LOW:
                begin
                    if (level == want)
                    begin
                        count_next = count_inc;
                        if (count_inc > {1'b0, threshold})
                        begin
                            // confirm the level, then go back to idle
                            if (level == active_high)
                            begin
                                status_next = 1'b1;
                                rise        = ~status_reg;
                            end
                            else
                            begin
                                status_next = 1'b0;
                            end
                            phase_next = mcid_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        phase_next = mcid_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    // latch the level and restart the count
                    phase_next = level ? mcid_pkg::PH_HIGH : mcid_pkg::PH_LOW;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mcid_pkg::PH_IDLE;
            count_reg  <= '0;
            status_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign res.status = status_next;
    assign res.rise   = rise;

endmodule

`default_nettype wire

// ===== hdl/mcid_merge.sv =====
// Merge stage: packs lane results into the result vectors and holds them
// in an output register backed by a skid register.
// Depends on mcid_pkg.
`default_nettype none

module mcid_merge #(
    parameter int CHANNELS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_fire,
    input  wire mcid_pkg::lane_res_t          lane_res [CHANNELS],
    output logic                              skid_full,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [mcid_pkg::FIELD_W-1:0]      active_status,
    output logic [mcid_pkg::FIELD_W-1:0]      newly_active
);

    logic [mcid_pkg::FIELD_W-1:0] status_vec;
    logic [mcid_pkg::FIELD_W-1:0] rise_vec;

    logic                         main_valid_reg;
    logic [mcid_pkg::FIELD_W-1:0] main_status_reg;
    logic [mcid_pkg::FIELD_W-1:0] main_rise_reg;
    logic                         skid_valid_reg;
    logic [mcid_pkg::FIELD_W-1:0] skid_status_reg;
    logic [mcid_pkg::FIELD_W-1:0] skid_rise_reg;
    logic                         out_fire;

    // Only lanes that map onto a field bit reach the result
    for (genvar i = 0; i < mcid_pkg::FIELD_W; i++)
    begin : g_pack
        if (i < CHANNELS)
        begin : g_lane
            assign status_vec[i] = lane_res[i].status;
            assign rise_vec[i]   = lane_res[i].rise;
        end
        else
        begin : g_none
            assign status_vec[i] = 1'b0;
            assign rise_vec[i]   = 1'b0;
        end
    end

    assign out_fire = main_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // input is stalled; refill the main register from skid
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_status_reg <= skid_status_reg;
                main_rise_reg   <= skid_rise_reg;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_ready)
            begin
                skid_status_reg <= status_vec;
                skid_rise_reg   <= rise_vec;
            end
            else
            begin
                main_status_reg <= status_vec;
                main_rise_reg   <= rise_vec;
            end
        end
    end

    assign skid_full     = skid_valid_reg;
    assign out_valid     = main_valid_reg;
    assign active_status = main_status_reg;
    assign newly_active  = main_rise_reg;

endmodule

`default_nettype wire

// ===== hdl/multi_channel_input_debounce_top.sv =====
// Top level of the multi-channel input debouncer: configuration registers,
// one debounce lane per channel and the merge/output stage.
// Depends on mcid_pkg, mcid_lane and mcid_merge.
`default_nettype none

// Each input transaction is one scan of raw pin levels, bit i for channel i.
// Every enabled channel runs its own debounce lane: the idle phase latches
// the level and clears the match count, the high or low phase counts
// matching scans, and once the count exceeds stable_threshold the status is
// set where the level equals the channel's active polarity (cleared
// otherwise) and the lane goes back to idle; a mismatching scan also goes
// back to idle. Disabled channels hold their state. Every scan yields one
// result transaction with the status vector and a pulse vector of channels
// that turned active in that scan. Lanes work in parallel and update in the
// cycle the scan is accepted, so a scan can be accepted every cycle while
// the skid register has room; the output register holds the result. A skid
// register behind the output register lets one more scan be accepted while
// a result waits; in_ready drops only while that skid register is full.
// Configuration writes take effect at the clock edge at which cfg_wr_en is
// high and must be issued only while the block is idle. Register indexes:
// 0 enable_mask, 1 active_high_mask, 2 stable_threshold; other indexes are
// ignored. Channels at or above bit 12 see level and enable as zero.
module multi_channel_input_debounce_top #(
    parameter int CHANNELS = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [mcid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mcid_pkg::FIELD_W-1:0]   cfg_data,
    // scan transactions
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mcid_pkg::FIELD_W-1:0]   raw_levels,
    // result transactions
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [mcid_pkg::FIELD_W-1:0]        active_status,
    output logic [mcid_pkg::FIELD_W-1:0]        newly_active
);

    logic [mcid_pkg::FIELD_W-1:0]  enable_mask_reg;
    logic [mcid_pkg::FIELD_W-1:0]  active_high_mask_reg;
    logic [mcid_pkg::THRESH_W-1:0] stable_threshold_reg;

    logic                          in_fire;
    logic                          skid_full;
    mcid_pkg::lane_res_t           lane_res [CHANNELS];

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg      <= mcid_pkg::ENABLE_MASK_RST;
            active_high_mask_reg <= mcid_pkg::ACTIVE_HIGH_MASK_RST;
            stable_threshold_reg <= mcid_pkg::STABLE_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mcid_pkg::REG_ENABLE_MASK:      enable_mask_reg      <= cfg_data;
                mcid_pkg::REG_ACTIVE_HIGH_MASK: active_high_mask_reg <= cfg_data;
                mcid_pkg::REG_STABLE_THRESHOLD:
                    stable_threshold_reg <= cfg_data[mcid_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept a scan whenever the skid register has room
    assign in_ready = ~skid_full;
    assign in_fire  = in_valid & in_ready;

    // One lane per channel; channels past the field width stay at reset
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic lvl;
        logic en;
        logic act_hi;

        if (i < mcid_pkg::FIELD_W)
        begin : g_mapped
            assign lvl    = raw_levels[i];
            assign en     = enable_mask_reg[i];
            assign act_hi = active_high_mask_reg[i];
        end
        else
        begin : g_unmapped
            assign lvl    = 1'b0;
            assign en     = 1'b0;
            assign act_hi = 1'b0;
        end

        mcid_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .accept      (in_fire),
            .level       (lvl),
            .enable      (en),
            .active_high (act_hi),
            .threshold   (stable_threshold_reg),
            .res         (lane_res[i])
        );
    end

    // Combine lane results and hold them for the consumer
    mcid_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .lane_res      (lane_res),
        .skid_full     (skid_full),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .active_status (active_status),
        .newly_active  (newly_active)
    );

endmodule

`default_nettype wire
